>>> src/efr_pkg.sv
package efr_pkg;

    // Line codes of the byte-stuffed framing.
    localparam logic [7:0] START_BYTE  = 8'h5A;
    localparam logic [7:0] ESCAPE_BYTE = 8'hEF;
    localparam logic [7:0] ANY_TYPE    = 8'h00;

    localparam int unsigned DEF_MAX_FRAME = 4096;
    localparam int unsigned MIN_FRAME     = 4;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned POS_W         = 12;
    localparam int unsigned LEN_W         = 16;
    localparam int unsigned QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_START,
        KIND_ESCAPE
    } t_efr_kind;

    typedef struct packed {
        t_efr_kind         kind;
        logic [BYTE_W-1:0] data;
    } t_efr_item;

endpackage

>>> src/escaped_frame_receiver.sv
// Channel        Direction  Handshake                 Payload
// rx words       in         push / full               i_rx_byte
// decoded words  out        empty / pop               o_data_byte, o_position,
//                                                     o_frame_end, o_overflow
// type filter    in         i_cfg_valid / o_cfg_ready i_cfg_data
//
// One word is taken every cycle while full is low; a decoded word passes the front
// register, which loads when its raw word is taken, then the queue and the result
// register. The back end decodes one word each cycle while no result waits unpopped.
// Reset is synchronous and active low; it clears the frame state and the type filter.
// A stalled pop holds the result register, the back end then stops, the two-entry
// queue fills, and full rises once the front register also holds a word.
module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = DEF_MAX_FRAME
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [POS_W-1:0]  o_position,
    output logic              o_frame_end,
    output logic              o_overflow,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_cfg_data
);

    // Front end to queue.
    logic      w_front_valid;
    t_efr_item w_front_item;
    logic      w_queue_ready;

    // Queue to back end.
    logic      w_back_valid;
    t_efr_item w_back_item;
    logic      w_back_ready;

    // The filter register can always be written.
    assign o_cfg_ready = 1'b1;

    // The front end classifies each raw word as start, escape or data.
    efr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .o_item_valid (w_front_valid),
        .o_item       (w_front_item),
        .i_item_ready (w_queue_ready)
    );

    // A short queue lets the front keep taking words while the result side stalls.
    efr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_queue_ready),
        .i_wr_item  (w_front_item),
        .o_rd_valid (w_back_valid),
        .i_rd_ready (w_back_ready),
        .o_rd_item  (w_back_item)
    );

    // The back end holds the frame state: unescaping, length and type capture,
    // frame end detection, overflow and the drop-until-start recovery.
    efr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_back_valid),
        .o_item_ready (w_back_ready),
        .i_item       (w_back_item),
        .empty        (empty),
        .pop          (pop),
        .o_data_byte  (o_data_byte),
        .o_position   (o_position),
        .o_frame_end  (o_frame_end),
        .o_overflow   (o_overflow)
    );

endmodule

>>> src/efr_front.sv
module efr_front
    import efr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_item_valid,
    output t_efr_item         o_item,
    input  logic              i_item_ready
);

    logic      r_valid;
    logic      n_valid;
    t_efr_item r_item;
    t_efr_item n_item;
    logic      w_accept;

    assign full     = r_valid && !i_item_ready;
    assign w_accept = push && !full;

    // Tag each received word with its role on the line.
    always_comb begin
        n_item.data = i_rx_byte;
        if (i_rx_byte == START_BYTE) begin
            n_item.kind = KIND_START;
        end else if (i_rx_byte == ESCAPE_BYTE) begin
            n_item.kind = KIND_ESCAPE;
        end else begin
            n_item.kind = KIND_DATA;
        end
        n_valid = w_accept || (r_valid && !i_item_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> src/efr_queue.sv
module efr_queue
    import efr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_valid,
    output logic      o_wr_ready,
    input  t_efr_item i_wr_item,
    output logic      o_rd_valid,
    input  logic      i_rd_ready,
    output t_efr_item o_rd_item
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_efr_item        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_wr_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> src/efr_back.sv
module efr_back
    import efr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = DEF_MAX_FRAME
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  t_efr_item         i_item,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [POS_W-1:0]  o_position,
    output logic              o_frame_end,
    output logic              o_overflow
);

    localparam int unsigned CNT_W  = $clog2(MAX_FRAME);
    localparam int unsigned NXT_W  = CNT_W + 1;
    localparam int unsigned CMP_W  = (NXT_W > LEN_W) ? NXT_W : LEN_W;
    localparam int unsigned PEXT_W = CNT_W + POS_W;

    logic [BYTE_W-1:0] r_type_filter;
    logic [CNT_W-1:0]  r_byte_count;
    logic [CNT_W-1:0]  n_byte_count;
    logic              r_escape_pending;
    logic              n_escape_pending;
    logic [LEN_W-1:0]  r_frame_length;
    logic [LEN_W-1:0]  n_frame_length;
    logic [BYTE_W-1:0] r_frame_type;
    logic [BYTE_W-1:0] n_frame_type;
    logic              r_discarding;
    logic              n_discarding;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_end;
    logic              r_out_ovf;

    logic              w_take;
    logic              w_load;
    logic [BYTE_W-1:0] w_byte;
    logic [NXT_W-1:0]  w_next;
    logic [PEXT_W-1:0] w_pos_ext;
    logic              w_ovf;
    logic              w_end;

    assign o_item_ready = !r_out_valid || pop;
    assign w_take       = i_item_valid && o_item_ready;
    assign w_byte       = r_escape_pending ? i_item.data + 1'b1 : i_item.data;
    assign w_next       = NXT_W'(r_byte_count) + 1'b1;
    assign w_pos_ext    = PEXT_W'(r_byte_count);
    assign w_ovf        = (w_next >= NXT_W'(MAX_FRAME));
    assign w_end        = !w_ovf && (w_next >= NXT_W'(MIN_FRAME))
                          && (CMP_W'(w_next) == CMP_W'(r_frame_length))
                          && ((r_type_filter == ANY_TYPE) || (r_type_filter == r_frame_type));

    always_comb begin
        n_byte_count     = r_byte_count;
        n_escape_pending = r_escape_pending;
        n_frame_length   = r_frame_length;
        n_frame_type     = r_frame_type;
        n_discarding     = r_discarding;
        n_out_valid      = r_out_valid && !pop;
        w_load           = 1'b0;
        if (w_take) begin
            case (i_item.kind)
                KIND_START: begin
                    n_byte_count     = '0;
                    n_escape_pending = 1'b0;
                    n_discarding     = 1'b0;
                end
                KIND_ESCAPE: begin
                    if (!r_discarding) begin
                        n_escape_pending = 1'b1;
                    end
                end
                KIND_DATA: begin
                    if (!r_discarding) begin
                        w_load           = 1'b1;
                        n_out_valid      = 1'b1;
                        n_escape_pending = 1'b0;
                        if (r_byte_count == CNT_W'(0)) begin
                            n_frame_length[BYTE_W-1:0] = w_byte;
                        end else if (r_byte_count == CNT_W'(1)) begin
                            n_frame_length[LEN_W-1:BYTE_W] = w_byte;
                        end else if (r_byte_count == CNT_W'(2)) begin
                            n_frame_type = w_byte;
                        end
                        if (w_ovf) begin
                            n_byte_count = '0;
                            n_discarding = 1'b1;
                        end else if (w_end) begin
                            n_byte_count = '0;
                        end else begin
                            n_byte_count = w_next[CNT_W-1:0];
                        end
                    end
                end
                default: begin
                    n_byte_count = r_byte_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_filter    <= ANY_TYPE;
            r_byte_count     <= '0;
            r_escape_pending <= 1'b0;
            r_frame_length   <= '0;
            r_frame_type     <= '0;
            r_discarding     <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_type_filter <= i_cfg_data;
            end
            r_byte_count     <= n_byte_count;
            r_escape_pending <= n_escape_pending;
            r_frame_length   <= n_frame_length;
            r_frame_type     <= n_frame_type;
            r_discarding     <= n_discarding;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_byte;
            r_out_pos  <= w_pos_ext[POS_W-1:0];
            r_out_end  <= w_end;
            r_out_ovf  <= w_ovf;
        end
    end

    assign empty       = !r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_position  = r_out_pos;
    assign o_frame_end = r_out_end;
    assign o_overflow  = r_out_ovf;

`ifndef SYNTH
    a_end_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_end && r_out_ovf))
        else $error("frame end and overflow on the same word");
    a_no_escape_while_dropping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_escape_pending && r_discarding))
        else $error("escape mark held while dropping");
    a_end_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_end || w_ovf)) |=> (r_byte_count == '0))
        else $error("count did not restart after frame end or overflow");
`endif

endmodule

>>> test/tb.sv
// Testbench for the escaped frame receiver.
//
// Raw line words go in through the push/full side. Each accepted word is also
// run through a local decoder that keeps its own copy of the frame state and
// of the type filter. Every word that should come out is queued. The receiver
// process pops decoded words; the checker compares each field with the oldest
// queued word. The tests run in order from one initial block: a directed byte
// sequence, type filter settings, a back-pressure test, random framed traffic
// over several filter settings, and a quiet tail.
module tb
    import efr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_LIMIT   = DEF_MAX_FRAME;
    // The raw word takes three register stages to reach the result ports.
    // The settle time also covers words that are still in flight and give no result.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 50;
    localparam int unsigned POS_LEN_LO    = 0;
    localparam int unsigned POS_LEN_HI    = 1;
    localparam int unsigned POS_TYPE      = 2;

    // One decoded word as it shows up on the result ports.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              frame_end;
        logic              overflow;
    } t_decoded;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              empty;
    logic              pop;
    logic [BYTE_W-1:0] o_data_byte;
    logic [POS_W-1:0]  o_position;
    logic              o_frame_end;
    logic              o_overflow;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_cfg_data;

    escaped_frame_receiver #(
        .MAX_FRAME (FRAME_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_rx_byte   (i_rx_byte),
        .empty       (empty),
        .pop         (pop),
        .o_data_byte (o_data_byte),
        .o_position  (o_position),
        .o_frame_end (o_frame_end),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the deframer state and of the type filter register.
    int unsigned       frame_count;
    logic              escape_armed;
    logic [LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0] frame_kind;
    logic              dropping;
    logic [BYTE_W-1:0] type_filter;

    // Decoded words still to come out of the block, oldest first.
    t_decoded          pending_words[$];
    t_decoded          want;

    // Run control and statistics.
    bit                idle_on;
    int unsigned       stall_left;
    int unsigned       hold_left;
    int unsigned       errors;
    int unsigned       raw_sent;
    int unsigned       words_predicted;
    int unsigned       words_checked;
    int unsigned       ends_seen;
    int unsigned       overflows_seen;
    int unsigned       input_stalls;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. The slowest correct run is well under a tenth of this.
    initial begin
        #4ms;
        $display("tb: done, errors");
        $finish;
    end

    // Works out what one raw word does to the frame state. Returns 1 and the
    // decoded word when the raw word produces a result.
    function automatic bit decode_word(input logic [BYTE_W-1:0] raw, output t_decoded d);
        logic [BYTE_W-1:0] b;
        int unsigned       at;
        b = raw;
        d = '0;
        // A start word restarts the frame from any state, even while dropping.
        if (raw == START_BYTE) begin
            frame_count  = 0;
            escape_armed = 1'b0;
            dropping     = 1'b0;
            return 1'b0;
        end
        // After an overflow everything up to the next start word is ignored.
        if (dropping)
            return 1'b0;
        // Escapes only arm the next word; a run of escapes still adds one once.
        if (raw == ESCAPE_BYTE) begin
            escape_armed = 1'b1;
            return 1'b0;
        end
        if (escape_armed) begin
            b = raw + 8'd1;
            escape_armed = 1'b0;
        end
        at = frame_count;
        case (at)
            POS_LEN_LO: frame_len[7:0]  = b;
            POS_LEN_HI: frame_len[15:8] = b;
            POS_TYPE:   frame_kind      = b;
            default: ;
        endcase
        frame_count = at + 1;
        d.data = b;
        d.pos  = at[POS_W-1:0];
        if (frame_count >= FRAME_LIMIT) begin
            // The word that fills the frame still comes out, flagged.
            d.overflow  = 1'b1;
            frame_count = 0;
            dropping    = 1'b1;
        end else if (frame_count >= MIN_FRAME && frame_count == frame_len &&
                     (type_filter == ANY_TYPE || type_filter == frame_kind)) begin
            // Lengths below the minimum never get here, so they never end a frame.
            d.frame_end = 1'b1;
            frame_count = 0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        errors++;
        // The count keeps going, but the log stays readable if everything breaks.
        if (errors <= MAX_REPORTS)
            $display("tb: mismatch in %s at decoded word %0d: got 0x%0h, want 0x%0h",
                     what, words_checked, got, exp_val);
    endtask

    // Offers one raw word and waits until the block takes it. Returns at a
    // falling edge with push still high, so back-to-back words need no gap.
    task automatic send_word(input logic [BYTE_W-1:0] raw);
        t_decoded    d;
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap  = $urandom_range(1, 3);
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      = 1'b1;
        i_rx_byte = raw;
        @(posedge i_clk);
        while (full) begin
            input_stalls++;
            @(posedge i_clk);
        end
        raw_sent++;
        if (decode_word(raw, d)) begin
            pending_words.push_back(d);
            words_predicted++;
        end
        @(negedge i_clk);
    endtask

    // Sends one logical frame word. Line codes must be escaped; other words
    // are escaped now and then too, sometimes behind a doubled escape. A word
    // whose predecessor is itself a line code cannot be sent escaped.
    task automatic send_plain(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] below;
        below = v - 8'd1;
        if (v == START_BYTE || v == ESCAPE_BYTE ||
            (below != START_BYTE && below != ESCAPE_BYTE && $urandom_range(0, 7) == 0)) begin
            send_word(ESCAPE_BYTE);
            if ($urandom_range(0, 5) == 0)
                send_word(ESCAPE_BYTE);
            send_word(below);
        end else begin
            send_word(v);
        end
    endtask

    // Sends n_words logical words: length low, length high, type, then payload.
    task automatic send_frame(input int unsigned n_words, input logic [LEN_W-1:0] len_field,
                              input logic [BYTE_W-1:0] kind, input bit with_start);
        int unsigned       i;
        logic [BYTE_W-1:0] v;
        if (with_start)
            send_word(START_BYTE);
        for (i = 0; i < n_words; i++) begin
            case (i)
                POS_LEN_LO: v = len_field[7:0];
                POS_LEN_HI: v = len_field[15:8];
                POS_TYPE:   v = kind;
                default:    v = BYTE_W'($urandom_range(0, 255));
            endcase
            send_plain(v);
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_kind();
        case ($urandom_range(0, 3))
            0:       return type_filter;
            1:       return 8'h00;
            2:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Stops offering words and waits until every expected word has come out,
    // then lets words that give no result clear the pipeline.
    task automatic wait_idle();
        push = 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_filter(input logic [BYTE_W-1:0] value);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        type_filter = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random traffic until the given number of decoded words has been queued.
    // Most of it is well-formed frames; the rest is noise, cut-off frames,
    // frames that follow on without a start word and odd length fields.
    task automatic random_frames(input int unsigned budget);
        int unsigned target;
        int unsigned n;
        int unsigned k;
        target = words_predicted + budget;
        while (words_predicted < target) begin
            case ($urandom_range(0, 11))
                0: begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        send_word(BYTE_W'($urandom_range(0, 255)));
                end
                1: begin
                    // Frame cut short by the next start word.
                    n = $urandom_range(4, 12);
                    send_frame($urandom_range(1, n - 1), LEN_W'(n), pick_kind(), 1'b1);
                end
                2: begin
                    // Length field below the minimum or fully random.
                    n = $urandom_range(1, 10);
                    if ($urandom_range(0, 1) == 0)
                        send_frame(n, LEN_W'($urandom_range(0, MIN_FRAME - 1)), pick_kind(),
                                   1'b1);
                    else
                        send_frame(n, LEN_W'($urandom_range(0, 16'hFFFF)), pick_kind(), 1'b1);
                end
                3: begin
                    n = $urandom_range(MIN_FRAME, 12);
                    send_frame(n, LEN_W'(n), pick_kind(), 1'b0);
                end
                default: begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(MIN_FRAME, 60)
                                                    : $urandom_range(MIN_FRAME, 14);
                    send_frame(n, LEN_W'(n), pick_kind(), 1'b1);
                end
            endcase
        end
    endtask

    // Line codes, escapes of the extreme values, a doubled escape, an escape
    // cancelled by a start word, a frame continuing without a start word, and a
    // short length field that never closes its frame.
    task automatic test_directed_bytes();
        logic [BYTE_W-1:0] seq[$];
        seq = '{START_BYTE, 8'h05, 8'h00, ANY_TYPE,
                ESCAPE_BYTE, 8'hFE, ESCAPE_BYTE, ESCAPE_BYTE, 8'h59,
                ESCAPE_BYTE, 8'hFF, ESCAPE_BYTE, START_BYTE,
                8'h03, 8'h00, 8'h07, 8'h11, 8'h22, 8'h33,
                START_BYTE, ESCAPE_BYTE, 8'hEE, 8'h00};
        foreach (seq[i])
            send_word(seq[i]);
    endtask

    // A set filter closes only frames of its own type; the others keep counting.
    task automatic test_type_filter();
        write_filter(8'h42);
        send_frame(6, 6, 8'h42, 1'b1);
        send_frame(5, 5, 8'h43, 1'b1);
        write_filter(8'hFF);
        send_frame(4, 4, 8'hFF, 1'b1);
        send_frame(4, 4, 8'hFE, 1'b1);
        write_filter(ANY_TYPE);
        send_frame(4, 4, 8'h77, 1'b1);
        send_frame(7, 7, 8'hFF, 1'b1);
    endtask

    // The receiver stops popping for a long stretch while frames keep coming,
    // so the block fills and holds off its input. Then the sender waits for
    // every word to come back before it goes on.
    task automatic test_backpressure();
        hold_left = 40;
        send_frame(9, 9, pick_kind(), 1'b1);
        send_frame(8, 8, pick_kind(), 1'b1);
        send_frame(10, 10, pick_kind(), 1'b1);
        wait_idle();
        send_frame(6, 6, pick_kind(), 1'b1);
    endtask

    // Four phases of random traffic, each under its own filter setting, with
    // idling switched on and off between phases.
    task automatic test_random_traffic();
        write_filter(ANY_TYPE);
        random_frames(60);
        idle_on = 1'b0;
        write_filter(BYTE_W'($urandom_range(1, 254)));
        random_frames(60);
        idle_on = 1'b1;
        write_filter(8'hFF);
        random_frames(60);
        write_filter(BYTE_W'($urandom_range(1, 255)));
        random_frames(60);
    endtask

    // Full rate on both sides to finish the run.
    task automatic test_quiet_tail();
        idle_on = 1'b0;
        write_filter(ANY_TYPE);
        random_frames(30);
    endtask

    // Receiver side: pops with random stalls, or holds off when asked.
    initial begin : receiver
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                pop = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                pop = 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Every popped word is checked against the oldest expected word.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word, data", 32'(o_data_byte), 0);
            end else begin
                want = pending_words.pop_front();
                if (o_data_byte !== want.data)
                    report_mismatch("data", 32'(o_data_byte), 32'(want.data));
                if (o_position !== want.pos)
                    report_mismatch("position", 32'(o_position), 32'(want.pos));
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame end", 32'(o_frame_end), 32'(want.frame_end));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_overflow), 32'(want.overflow));
            end
            words_checked++;
            if (o_frame_end === 1'b1)
                ends_seen++;
            if (o_overflow === 1'b1)
                overflows_seen++;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_rx_byte    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        idle_on      = 1'b1;
        stall_left   = 0;
        hold_left    = 0;
        frame_count  = 0;
        escape_armed = 1'b0;
        frame_len    = '0;
        frame_kind   = '0;
        dropping     = 1'b0;
        type_filter  = ANY_TYPE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_filter(ANY_TYPE);
        test_directed_bytes();
        test_type_filter();
        test_backpressure();
        test_random_traffic();
        test_quiet_tail();

        idle_on = 1'b0;
        wait_idle();
        $display("tb: %0d raw words sent, %0d decoded words checked, %0d input stall cycles",
                 raw_sent, words_checked, input_stalls);
        $display("tb: %0d frames closed and %0d overflows, filters any, 0xFF and random types",
                 ends_seen, overflows_seen);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
src/efr_pkg.sv
src/efr_front.sv
src/efr_queue.sv
src/efr_back.sv
src/escaped_frame_receiver.sv
test/tb.sv
